[hw/rtl/tli_pkg.sv]
// Package for the two-line intersection block: transaction types, datapath
// widths and the coordinate limits. Depends on nothing.
`timescale 1ns / 1ps

package tli_pkg;

   // Coordinate format, Q16.16 two's complement
   localparam int COORD_WIDTH = 32;

   // Datapath widths, all exact
   localparam int DIFF_W = COORD_WIDTH + 1;           // line coefficient a or b
   localparam int PA_W   = DIFF_W + COORD_WIDTH;      // coefficient times coordinate
   localparam int PD_W   = 2 * DIFF_W;                // coefficient times coefficient
   localparam int C_W    = PA_W + 1;                  // line constant c
   localparam int DET_W  = PD_W + 1;                  // determinant
   localparam int LO_W   = DIFF_W;                    // low slice of c
   localparam int HI_W   = C_W - LO_W;                // high slice of c
   localparam int PH_W   = DIFF_W + HI_W;             // partial product, high slice
   localparam int PL_W   = DIFF_W + LO_W + 1;         // partial product, low slice
   localparam int TERM_W = DIFF_W + C_W;              // coefficient times c
   localparam int NUM_W  = TERM_W + 1;                // Cramer numerator

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] d_x;
      logic signed [COORD_WIDTH-1:0] d_y;
   } tli_req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cross_x;
      logic signed [COORD_WIDTH-1:0] cross_y;
      logic                          parallel;
      logic                          clipped;
   } tli_rsp_type;

   // Quotient from one divider lane
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] value;
      logic                          clip;
      logic                          zero;
   } tli_quo_type;

endpackage

[hw/rtl/tli_front.sv]
// Front pipeline: line coefficients, line constants, determinant and the
// two Cramer numerators in six register stages. Depends on tli_pkg.
`timescale 1ns / 1ps

module tli_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  tli_pkg::tli_req_type                  in_data,
   output logic                                  out_valid,
   output logic signed [tli_pkg::NUM_W-1:0]      out_nx,
   output logic signed [tli_pkg::NUM_W-1:0]      out_ny,
   output logic signed [tli_pkg::DET_W-1:0]      out_det
);

   localparam int W      = tli_pkg::COORD_WIDTH;
   localparam int DIFF_W = tli_pkg::DIFF_W;
   localparam int PA_W   = tli_pkg::PA_W;
   localparam int PD_W   = tli_pkg::PD_W;
   localparam int C_W    = tli_pkg::C_W;
   localparam int DET_W  = tli_pkg::DET_W;
   localparam int LO_W   = tli_pkg::LO_W;
   localparam int HI_W   = tli_pkg::HI_W;
   localparam int PH_W   = tli_pkg::PH_W;
   localparam int PL_W   = tli_pkg::PL_W;
   localparam int TERM_W = tli_pkg::TERM_W;
   localparam int NUM_W  = tli_pkg::NUM_W;

   logic [6:1] valid_ff;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:1], in_valid};
      end
   end

   // Stage 1: line coefficients
   logic signed [DIFF_W-1:0] s1_a1_in, s1_b1_in, s1_a2_in, s1_b2_in;
   logic signed [DIFF_W-1:0] s1_a1_ff, s1_b1_ff, s1_a2_ff, s1_b2_ff;
   logic signed [W-1:0]      s1_ax_ff, s1_ay_ff, s1_cx_ff, s1_cy_ff;

   always_comb begin
      s1_a1_in = DIFF_W'(in_data.b_y) - DIFF_W'(in_data.a_y);
      s1_b1_in = DIFF_W'(in_data.a_x) - DIFF_W'(in_data.b_x);
      s1_a2_in = DIFF_W'(in_data.d_y) - DIFF_W'(in_data.c_y);
      s1_b2_in = DIFF_W'(in_data.c_x) - DIFF_W'(in_data.d_x);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a1_ff <= s1_a1_in;
         s1_b1_ff <= s1_b1_in;
         s1_a2_ff <= s1_a2_in;
         s1_b2_ff <= s1_b2_in;
         s1_ax_ff <= in_data.a_x;
         s1_ay_ff <= in_data.a_y;
         s1_cx_ff <= in_data.c_x;
         s1_cy_ff <= in_data.c_y;
      end
   end

   // Stage 2: first-level products
   logic signed [PA_W-1:0]   s2_t1a_in, s2_t2a_in, s2_t1c_in, s2_t2c_in;
   logic signed [PD_W-1:0]   s2_dp1_in, s2_dp2_in;
   logic signed [PA_W-1:0]   s2_t1a_ff, s2_t2a_ff, s2_t1c_ff, s2_t2c_ff;
   logic signed [PD_W-1:0]   s2_dp1_ff, s2_dp2_ff;
   logic signed [DIFF_W-1:0] s2_a1_ff, s2_b1_ff, s2_a2_ff, s2_b2_ff;

   always_comb begin
      s2_t1a_in = s1_a1_ff * s1_ax_ff;
      s2_t2a_in = s1_b1_ff * s1_ay_ff;
      s2_t1c_in = s1_a2_ff * s1_cx_ff;
      s2_t2c_in = s1_b2_ff * s1_cy_ff;
      s2_dp1_in = s1_a1_ff * s1_b2_ff;
      s2_dp2_in = s1_a2_ff * s1_b1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_t1a_ff <= s2_t1a_in;
         s2_t2a_ff <= s2_t2a_in;
         s2_t1c_ff <= s2_t1c_in;
         s2_t2c_ff <= s2_t2c_in;
         s2_dp1_ff <= s2_dp1_in;
         s2_dp2_ff <= s2_dp2_in;
         s2_a1_ff  <= s1_a1_ff;
         s2_b1_ff  <= s1_b1_ff;
         s2_a2_ff  <= s1_a2_ff;
         s2_b2_ff  <= s1_b2_ff;
      end
   end

   // Stage 3: line constants and determinant
   logic signed [C_W-1:0]    s3_c1_in, s3_c2_in, s3_c1_ff, s3_c2_ff;
   logic signed [DET_W-1:0]  s3_det_in, s3_det_ff;
   logic signed [DIFF_W-1:0] s3_a1_ff, s3_b1_ff, s3_a2_ff, s3_b2_ff;

   always_comb begin
      s3_c1_in  = C_W'(s2_t1a_ff) + C_W'(s2_t2a_ff);
      s3_c2_in  = C_W'(s2_t1c_ff) + C_W'(s2_t2c_ff);
      s3_det_in = DET_W'(s2_dp1_ff) - DET_W'(s2_dp2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_c1_ff  <= s3_c1_in;
         s3_c2_ff  <= s3_c2_in;
         s3_det_ff <= s3_det_in;
         s3_a1_ff  <= s2_a1_ff;
         s3_b1_ff  <= s2_b1_ff;
         s3_a2_ff  <= s2_a2_ff;
         s3_b2_ff  <= s2_b2_ff;
      end
   end

   // Stage 4: partial products of coefficient times split constant
   logic signed [HI_W-1:0]  c1_hi, c2_hi;
   logic signed [LO_W:0]    c1_lo, c2_lo;
   logic signed [PH_W-1:0]  s4_bx1h_in, s4_bx2h_in, s4_ay1h_in, s4_ay2h_in;
   logic signed [PL_W-1:0]  s4_bx1l_in, s4_bx2l_in, s4_ay1l_in, s4_ay2l_in;
   logic signed [PH_W-1:0]  s4_bx1h_ff, s4_bx2h_ff, s4_ay1h_ff, s4_ay2h_ff;
   logic signed [PL_W-1:0]  s4_bx1l_ff, s4_bx2l_ff, s4_ay1l_ff, s4_ay2l_ff;
   logic signed [DET_W-1:0] s4_det_ff;

   always_comb begin
      c1_hi      = $signed(s3_c1_ff[C_W-1:LO_W]);
      c2_hi      = $signed(s3_c2_ff[C_W-1:LO_W]);
      c1_lo      = $signed({1'b0, s3_c1_ff[LO_W-1:0]});
      c2_lo      = $signed({1'b0, s3_c2_ff[LO_W-1:0]});
      s4_bx1h_in = s3_b2_ff * c1_hi;
      s4_bx1l_in = s3_b2_ff * c1_lo;
      s4_bx2h_in = s3_b1_ff * c2_hi;
      s4_bx2l_in = s3_b1_ff * c2_lo;
      s4_ay1h_in = s3_a1_ff * c2_hi;
      s4_ay1l_in = s3_a1_ff * c2_lo;
      s4_ay2h_in = s3_a2_ff * c1_hi;
      s4_ay2l_in = s3_a2_ff * c1_lo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_bx1h_ff <= s4_bx1h_in;
         s4_bx1l_ff <= s4_bx1l_in;
         s4_bx2h_ff <= s4_bx2h_in;
         s4_bx2l_ff <= s4_bx2l_in;
         s4_ay1h_ff <= s4_ay1h_in;
         s4_ay1l_ff <= s4_ay1l_in;
         s4_ay2h_ff <= s4_ay2h_in;
         s4_ay2l_ff <= s4_ay2l_in;
         s4_det_ff  <= s3_det_ff;
      end
   end

   // Stage 5: recombine partial products
   logic signed [TERM_W-1:0] s5_bx1_in, s5_bx2_in, s5_ay1_in, s5_ay2_in;
   logic signed [TERM_W-1:0] s5_bx1_ff, s5_bx2_ff, s5_ay1_ff, s5_ay2_ff;
   logic signed [DET_W-1:0]  s5_det_ff;

   always_comb begin
      s5_bx1_in = (TERM_W'(s4_bx1h_ff) <<< LO_W) + TERM_W'(s4_bx1l_ff);
      s5_bx2_in = (TERM_W'(s4_bx2h_ff) <<< LO_W) + TERM_W'(s4_bx2l_ff);
      s5_ay1_in = (TERM_W'(s4_ay1h_ff) <<< LO_W) + TERM_W'(s4_ay1l_ff);
      s5_ay2_in = (TERM_W'(s4_ay2h_ff) <<< LO_W) + TERM_W'(s4_ay2l_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_bx1_ff <= s5_bx1_in;
         s5_bx2_ff <= s5_bx2_in;
         s5_ay1_ff <= s5_ay1_in;
         s5_ay2_ff <= s5_ay2_in;
         s5_det_ff <= s4_det_ff;
      end
   end

   // Stage 6: numerators
   logic signed [NUM_W-1:0] s6_nx_in, s6_ny_in, s6_nx_ff, s6_ny_ff;
   logic signed [DET_W-1:0] s6_det_ff;

   always_comb begin
      s6_nx_in = NUM_W'(s5_bx1_ff) - NUM_W'(s5_bx2_ff);
      s6_ny_in = NUM_W'(s5_ay1_ff) - NUM_W'(s5_ay2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_nx_ff  <= s6_nx_in;
         s6_ny_ff  <= s6_ny_in;
         s6_det_ff <= s5_det_ff;
      end
   end

   assign out_valid = valid_ff[6];
   assign out_nx    = s6_nx_ff;
   assign out_ny    = s6_ny_ff;
   assign out_det   = s6_det_ff;

endmodule

[hw/rtl/tli_div.sv]
// Pipelined restoring divider: rounded, saturated quotient of numerator by
// determinant, one quotient bit per stage. Depends on tli_pkg.
`timescale 1ns / 1ps

module tli_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [tli_pkg::NUM_W-1:0]  in_num,
   input  logic signed [tli_pkg::DET_W-1:0]  in_den,
   output logic                              out_valid,
   output tli_pkg::tli_quo_type              out_quo
);

   localparam int W     = tli_pkg::COORD_WIDTH;
   localparam int NUM_W = tli_pkg::NUM_W;
   localparam int DET_W = tli_pkg::DET_W;
   localparam int R_W   = NUM_W + 2;
   localparam int D_W   = DET_W + 1;

   // Stage D0: signs and magnitudes
   logic             d0_valid_ff, d0_neg_ff, d0_zero_ff;
   logic [NUM_W-1:0] d0_mn_in, d0_mn_ff;
   logic [DET_W-1:0] d0_md_in, d0_md_ff;

   always_comb begin
      d0_mn_in = in_num[NUM_W-1] ? $unsigned(-in_num) : $unsigned(in_num);
      d0_md_in = in_den[DET_W-1] ? $unsigned(-in_den) : $unsigned(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (en) begin
         d0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_neg_ff  <= in_num[NUM_W-1] ^ in_den[DET_W-1];
         d0_zero_ff <= (in_den == '0);
         d0_mn_ff   <= d0_mn_in;
         d0_md_ff   <= d0_md_in;
      end
   end

   // Stage D1: fold rounding into the operands, (2n + d) / 2d
   logic           d1_valid_ff, d1_neg_ff, d1_zero_ff;
   logic [R_W-1:0] d1_num_in, d1_num_ff;
   logic [D_W-1:0] d1_den_in, d1_den_ff;

   always_comb begin
      d1_num_in = R_W'({d0_mn_ff, 1'b0}) + R_W'(d0_md_ff);
      d1_den_in = {d0_md_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (en) begin
         d1_valid_ff <= d0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_neg_ff  <= d0_neg_ff;
         d1_zero_ff <= d0_zero_ff;
         d1_num_ff  <= d1_num_in;
         d1_den_ff  <= d1_den_in;
      end
   end

   // Stage D2: flag a quotient too large for the result width
   logic           st_valid_ff [0:W];
   logic           st_neg_ff   [0:W];
   logic           st_zero_ff  [0:W];
   logic           st_ovf_ff   [0:W];
   logic [R_W-1:0] st_rem_ff   [0:W];
   logic [D_W-1:0] st_den_ff   [0:W];
   logic [W-1:0]   st_q_ff     [0:W];
   logic           d2_ovf_in;

   assign d2_ovf_in = d1_num_ff >= (R_W'(d1_den_ff) << W);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else if (en) begin
         st_valid_ff[0] <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_neg_ff[0]  <= d1_neg_ff;
         st_zero_ff[0] <= d1_zero_ff;
         st_ovf_ff[0]  <= d2_ovf_in;
         st_rem_ff[0]  <= d1_num_ff;
         st_den_ff[0]  <= d1_den_ff;
         st_q_ff[0]    <= '0;
      end
   end

   // Quotient stages, most significant bit first
   for (genvar k = 0; k < W; k++) begin : g_step
      localparam int BIT = W - 1 - k;
      logic [R_W-1:0] cmp;
      logic           take;
      logic [R_W-1:0] rem_in;
      logic [W-1:0]   q_in;

      always_comb begin
         cmp       = R_W'(st_den_ff[k]) << BIT;
         take      = st_rem_ff[k] >= cmp;
         rem_in    = take ? (st_rem_ff[k] - cmp) : st_rem_ff[k];
         q_in      = st_q_ff[k];
         q_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            st_valid_ff[k+1] <= st_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_neg_ff[k+1]  <= st_neg_ff[k];
            st_zero_ff[k+1] <= st_zero_ff[k];
            st_ovf_ff[k+1]  <= st_ovf_ff[k];
            st_rem_ff[k+1]  <= rem_in;
            st_den_ff[k+1]  <= st_den_ff[k];
            st_q_ff[k+1]    <= q_in;
         end
      end
   end

   // Final stage: clamp, apply sign, substitute the parallel answer
   logic                 out_valid_ff;
   tli_pkg::tli_quo_type quo_in, quo_ff;
   logic [W-1:0]         lim;
   logic [W-1:0]         mag;
   logic                 sat;

   always_comb begin
      lim = st_neg_ff[W] ? tli_pkg::COORD_MIN : tli_pkg::COORD_MAX;
      sat = st_ovf_ff[W] || (st_q_ff[W] > lim);
      mag = sat ? lim : st_q_ff[W];
      if (st_zero_ff[W]) begin
         quo_in.value = tli_pkg::COORD_MAX;
         quo_in.clip  = 1'b0;
         quo_in.zero  = 1'b1;
      end else begin
         quo_in.value = st_neg_ff[W] ? $signed(-mag) : $signed(mag);
         quo_in.clip  = sat;
         quo_in.zero  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= st_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = quo_ff;

endmodule

[hw/rtl/two_line_intersection.sv]
// Two-line intersection by Cramer's rule, top level.
// Uses tli_pkg, tli_front and two tli_div lanes.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one line pair (A,B and C,D, signed Q16.16) per transaction,
//   taken at a rising edge with req_valid high and req_stall low.
//   rsp_* returns one result per transaction, in order: the intersection
//   point, rounded to nearest and clamped to the Q16.16 range (clipped set
//   when clamped), or the largest positive coordinate with parallel set
//   when the determinant is zero.
// Path: from acceptance to rsp_valid through six front stages
//   (coefficients, products, constants, split products, recombine,
//   numerators), three divider setup stages, 32 quotient-bit stages and
//   the output register.
// Throughput: one transaction per cycle unless stalled; a stage holds one.
// Reset: synchronous, clears every valid bit; data is not reset.
// Stall: while a result is held with rsp_stall high the whole pipeline
//   holds and req_stall goes high; nothing is dropped or repeated.

module two_line_intersection (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tli_pkg::tli_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tli_pkg::tli_rsp_type  rsp_data
);

   logic                                en;
   logic                                front_valid;
   logic signed [tli_pkg::NUM_W-1:0]    front_nx, front_ny;
   logic signed [tli_pkg::DET_W-1:0]    front_det;
   tli_pkg::tli_quo_type                quo_x, quo_y;
   logic                                lane_y_valid;

   // Advance the pipeline unless a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   tli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_nx    (front_nx),
      .out_ny    (front_ny),
      .out_det   (front_det)
   );

   tli_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_num    (front_nx),
      .in_den    (front_det),
      .out_valid (rsp_valid),
      .out_quo   (quo_x)
   );

   tli_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_num    (front_ny),
      .in_den    (front_det),
      .out_valid (lane_y_valid),
      .out_quo   (quo_y)
   );

   // Merge the two lanes into the result transaction
   always_comb begin
      rsp_data.cross_x  = quo_x.value;
      rsp_data.cross_y  = quo_y.value;
      rsp_data.parallel = quo_x.zero;
      rsp_data.clipped  = quo_x.clip || quo_y.clip;
   end

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_parallel_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parallel |->
         rsp_data.cross_x == tli_pkg::COORD_MAX && rsp_data.cross_y == tli_pkg::COORD_MAX
         && !rsp_data.clipped)
      else $error("parallel result without maximum coordinates");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.cross_x == tli_pkg::COORD_MAX || rsp_data.cross_x == tli_pkg::COORD_MIN ||
         rsp_data.cross_y == tli_pkg::COORD_MAX || rsp_data.cross_y == tli_pkg::COORD_MIN)
      else $error("clipped result not at a range bound");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no held result");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_y_valid == rsp_valid)
      else $error("divider lanes out of step");
`endif

endmodule
